// File: rtl/core/bounding_box_normalizer_core_assert.svh
// Assertion macros used by the bounding box normalizer core.
`ifndef BOUNDING_BOX_NORMALIZER_CORE_ASSERT_SVH
`define BOUNDING_BOX_NORMALIZER_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define BBN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define BBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer package
// Shared constants, status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package bbn_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordWidth  = 16;
  localparam int AddrWidth   = $clog2(MaxVertices);
  localparam int CountWidth  = $clog2(MaxVertices + 1);
  // Sum of two coordinates and twice a coordinate minus a sum.
  localparam int SumWidth    = CoordWidth + 1;
  localparam int DiffWidth   = CoordWidth + 2;
  // Extent is unsigned and fits CoordWidth bits.
  localparam int ExtWidth    = CoordWidth;
  // Dividend magnitude 2*|d|*16384 + E needs DiffWidth+16 bits.
  localparam int NumWidth    = DiffWidth + 16;
  // Quotient fits 15 bits (at most 16384).
  localparam int QuoWidth    = 15;
  localparam int NormWidth   = 16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_DEGENERATE = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // store a vertex and update the box
    logic clear;       // return the mesh state to reset
    logic calc_box;    // register sums and extent
    logic div_start;   // start the three dividers on the vertex at rd_addr
    logic rd_en;       // read store at rd_addr
    logic [AddrWidth-1:0] rd_addr;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic overflow;
    logic degenerate;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/bounding_box_normalizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer core
// Usage:
//   in_*  : vertex items (in_tuser = 0) carry x, y, z in signed Q8.8 and are
//           taken one per cycle while the block is idle; an end item (in_tuser = 1) starts the run.
//   out_* : one item per stored vertex, normalized to signed Q1.14 in the
//           cube [-1, 1], out_tlast on the final one; or a single status item.
//   cfg_* : min_extent, written while the block is idle.
// Sequence: vertex items give no result. An end item first evaluates the box
//   (S_BOX, S_CHECK); then each vertex needs a read, a divider start, 34
//   shift-subtract steps plus a done flag (three dividers in parallel, one per
//   axis) and an issue. Empty and overflow status items are issued straight
//   from S_STATUS after the end item, a degenerate one after S_BOX and S_CHECK.
// Reset clears the mesh and sets min_extent to zero; the vertex memory itself
//   is not cleared. When the receiver stalls, the finished item waits in the
//   output register and the sequence holds; vertex loading resumes after the run ends.
// ----------------------------------------------------------------------------
module bounding_box_normalizer_core
  import bbn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // x_coord, y_coord, z_coord
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // norm_x, norm_y, norm_z
  output logic [1:0]       out_tuser,  // status
  output logic             out_tlast,  // last_result
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]                  min_extent_r;
  dp_cmd_t                      cmd;
  dp_stat_t                     stat;
  logic signed [NormWidth-1:0]  nx, ny, nz;
  logic [3*NormWidth-1:0]       data_r;
  logic                         out_zero;
  logic                         out_take;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_extent_r <= '0;
    end else if (cfg_we) begin
      min_extent_r <= cfg_wdata;
    end
  end

  bbn_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_kind    (in_tuser),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_last   (out_tlast),
    .out_zero   (out_zero),
    .out_take   (out_take),
    .cmd        (cmd),
    .stat       (stat)
  );

  bbn_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_x       (in_tdata[15:0]),
    .in_y       (in_tdata[31:16]),
    .in_z       (in_tdata[47:32]),
    .min_extent (min_extent_r),
    .stat       (stat),
    .norm_x     (nx),
    .norm_y     (ny),
    .norm_z     (nz)
  );

  // Output data register, loaded with the item the controller issues.
  always_ff @(posedge clk) begin
    if (out_take) begin
      data_r <= {nz, ny, nx};
    end
  end

  assign out_tdata = out_zero ? {(3*NormWidth){1'b0}} : data_r;

`include "bounding_box_normalizer_core_assert.svh"

  `BBN_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "item dropped")
  `BBN_ASSERT_IMPL(a_status_last, clk, rst_n, out_tvalid && out_tuser != ST_OK, out_tlast,
                   "status item without last")
  `BBN_ASSERT_IMPL(a_no_load_busy, clk, rst_n, cmd.load, !cmd.rd_en, "load during run")

endmodule
`default_nettype wire

// File: rtl/core/bbn_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer divider
// Restoring divider, one quotient bit per cycle, with round-half-away sign.
// ----------------------------------------------------------------------------
module bbn_divider
  import bbn_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [DiffWidth-1:0] diff,
  input  wire logic [ExtWidth-1:0]         ext,
  output logic                             done,
  output logic signed [NormWidth-1:0]      result
);

  localparam int StepWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0]  num_r, num_nxt;
  logic [NumWidth:0]    rem_r, rem_nxt;
  logic [NumWidth:0]    den_r;
  logic [StepWidth-1:0] step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 neg_r;
  logic [DiffWidth-1:0] mag;
  logic [NumWidth:0]    shifted;

  assign mag     = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
  assign shifted = {rem_r[NumWidth-1:0], num_r[NumWidth-1]};

  // One shift-subtract step per cycle.
  always_comb begin
    num_nxt  = {num_r[NumWidth-2:0], 1'b0};
    rem_nxt  = shifted;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (shifted >= den_r) begin
        rem_nxt    = shifted - den_r;
        num_nxt[0] = 1'b1;
      end
      step_nxt = step_r - StepWidth'(1);
      if (step_r == StepWidth'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && (step_r == StepWidth'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= StepWidth'(NumWidth);
      end else begin
        busy_r <= busy_nxt;
        step_r <= step_nxt;
      end
    end
  end

  // Dividend 2*|d|*16384 + E, divisor 2*E; the quotient replaces num_r.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (NumWidth'(mag) << 15) + NumWidth'(ext);
      rem_r <= '0;
      den_r <= (NumWidth+1)'(ext) << 1;
      neg_r <= diff[DiffWidth-1];
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign result = neg_r ? -NormWidth'(num_r[QuoWidth-1:0])
                        :  NormWidth'(num_r[QuoWidth-1:0]);

endmodule
`default_nettype wire

// File: rtl/core/bbn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer datapath
// Vertex memory, running box, extent logic and three per-axis dividers.
// ----------------------------------------------------------------------------
module bbn_datapath
  import bbn_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dp_cmd_t                      cmd,
  input  wire logic signed [CoordWidth-1:0] in_x,
  input  wire logic signed [CoordWidth-1:0] in_y,
  input  wire logic signed [CoordWidth-1:0] in_z,
  input  wire logic [15:0]                  min_extent,
  output dp_stat_t                          stat,
  output logic signed [NormWidth-1:0]       norm_x,
  output logic signed [NormWidth-1:0]       norm_y,
  output logic signed [NormWidth-1:0]       norm_z
);

  localparam logic signed [CoordWidth-1:0] CoordTop = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] CoordBot = {1'b1, {(CoordWidth-1){1'b0}}};

  logic [3*CoordWidth-1:0] mem [MaxVertices];
  logic [3*CoordWidth-1:0] rd_data_r;

  logic [CountWidth-1:0]         count_r;
  logic                          ovf_r;
  logic signed [CoordWidth-1:0]  min_r [3];
  logic signed [CoordWidth-1:0]  max_r [3];
  logic signed [SumWidth-1:0]    sum_r [3];
  logic [ExtWidth-1:0]           ext_r;
  logic [ExtWidth-1:0]           ext_nxt;
  logic [ExtWidth-1:0]           axis_ext [3];
  logic signed [CoordWidth-1:0]  in_v [3];
  logic signed [DiffWidth-1:0]   diff [3];
  logic signed [NormWidth-1:0]   res [3];
  logic [2:0]                    done;

  assign in_v[0] = in_x;
  assign in_v[1] = in_y;
  assign in_v[2] = in_z;

  // Vertex store, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CountWidth'(MaxVertices)) begin
      mem[count_r[AddrWidth-1:0]] <= {in_z, in_y, in_x};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Count, overflow flag and running box.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_r[a] <= CoordTop;
        max_r[a] <= CoordBot;
      end
    end else if (cmd.load) begin
      if (count_r < CountWidth'(MaxVertices)) begin
        count_r <= count_r + CountWidth'(1);
        for (int a = 0; a < 3; a++) begin
          if (in_v[a] < min_r[a]) min_r[a] <= in_v[a];
          if (in_v[a] > max_r[a]) max_r[a] <= in_v[a];
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Largest extent over the three axes.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_ext[a] = ExtWidth'(SumWidth'(max_r[a]) - SumWidth'(min_r[a]));
    end
    ext_nxt = axis_ext[0];
    if (axis_ext[1] > ext_nxt) ext_nxt = axis_ext[1];
    if (axis_ext[2] > ext_nxt) ext_nxt = axis_ext[2];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_box) begin
      ext_r <= ext_nxt;
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= SumWidth'(min_r[a]) + SumWidth'(max_r[a]);
      end
    end
  end

  // Offsets of the read vertex from the box center, doubled.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = (DiffWidth'(signed'(rd_data_r[a*CoordWidth +: CoordWidth])) <<< 1)
              - DiffWidth'(sum_r[a]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    bbn_divider u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (cmd.div_start),
      .diff   (diff[g]),
      .ext    (ext_r),
      .done   (done[g]),
      .result (res[g])
    );
  end

  assign norm_x = res[0];
  assign norm_y = res[1];
  assign norm_z = res[2];

  assign stat.count      = count_r;
  assign stat.overflow   = ovf_r;
  assign stat.degenerate = (ext_r <= min_extent);
  assign stat.div_done   = &done;

endmodule
`default_nettype wire

// File: rtl/core/bbn_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer controller
// Sequences loading, box evaluation, per-vertex division and the result item.
// ----------------------------------------------------------------------------
module bbn_controller
  import bbn_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire logic   in_kind,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic        out_zero,
  output logic        out_take,
  output dp_cmd_t     cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_BOX, S_CHECK, S_READ, S_DIV, S_EMIT, S_STATUS
  } state_t;

  state_t                state_r;
  logic [AddrWidth-1:0]  idx_r;
  logic [1:0]            status_r;
  logic [1:0]            out_status_r;
  logic                  last_r;
  logic                  accept;
  logic                  out_fire;
  logic                  issue;
  logic                  is_last;
  logic                  run_end;

  assign accept   = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign is_last  = (CountWidth'(idx_r) + CountWidth'(1)) == stat.count;
  // An item is issued once the output register is free or being emptied.
  assign issue    = (state_r == S_STATUS) && (!out_valid || out_ready);
  // A status item or the final vertex ends the run.
  assign run_end  = (status_r != ST_OK) || is_last;
  // The output register may still hold an item while the next vertex loads.
  assign in_ready = (state_r == S_IDLE);

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.load      = accept && !in_kind;
    cmd.calc_box  = (state_r == S_BOX);
    cmd.rd_addr   = idx_r;
    cmd.rd_en     = (state_r == S_READ);
    cmd.div_start = (state_r == S_DIV);
    cmd.clear     = issue && run_end;
  end

  assign out_status = out_status_r;
  assign out_last   = last_r;
  assign out_take   = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      status_r     <= ST_OK;
      out_status_r <= ST_OK;
      last_r       <= 1'b0;
      out_valid    <= 1'b0;
      out_zero     <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_kind) begin
            idx_r <= '0;
            if (stat.count == '0) begin
              status_r <= ST_EMPTY;
              state_r  <= S_STATUS;
            end else if (stat.overflow) begin
              status_r <= ST_OVERFLOW;
              state_r  <= S_STATUS;
            end else begin
              state_r <= S_BOX;
            end
          end
        end
        S_BOX: state_r <= S_CHECK;
        S_CHECK: begin
          if (stat.degenerate) begin
            status_r <= ST_DEGENERATE;
            state_r  <= S_STATUS;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_DIV;
        S_DIV: state_r <= S_EMIT;
        S_EMIT: begin
          // Wait for the quotient.
          if (stat.div_done) begin
            state_r <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (issue) begin
            out_status_r <= status_r;
            out_zero     <= (status_r != ST_OK);
            last_r       <= run_end;
            if (!run_end) begin
              idx_r   <= idx_r + AddrWidth'(1);
              state_r <= S_READ;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer testbench
// Streams meshes of vertices and end items into the core, predicts the
// normalized vertices and status items, and compares every output item.
// ----------------------------------------------------------------------------

// Predicts normalized output items from the accepted meshes and checks them.
class mesh_scoreboard;
  logic signed [15:0] store_x[64], store_y[64], store_z[64];
  int count;
  bit overflowed;
  int lo[3], hi[3];
  int min_extent;
  logic [50:0] pending[$];  // {nx, ny, nz, status, last}
  int mismatches;
  int checked;

  function new();
    min_extent = 0;
    mismatches = 0;
    checked = 0;
    clear_mesh();
  endfunction

  function void clear_mesh();
    count = 0;
    overflowed = 0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = 32767;
      hi[a] = -32768;
    end
  endfunction

  // Rounds d * 16384 / e to nearest, ties away from zero.
  function int scaled(int d, int e);
    longint mag;
    longint q;
    mag = (d < 0 ? -d : d) * 64'sd16384;
    q = (2 * mag + e) / (2 * e);
    return d < 0 ? -q : q;
  endfunction

  // Notes one accepted input item and queues the results it causes.
  function void note_input(bit is_end, logic [47:0] data);
    int v[3];
    int s[3];
    int ext;
    bbn_pkg::status_t st;
    if (!is_end) begin
      if (count >= 64) begin
        overflowed = 1;
        return;
      end
      v[0] = $signed(data[15:0]);
      v[1] = $signed(data[31:16]);
      v[2] = $signed(data[47:32]);
      store_x[count] = v[0];
      store_y[count] = v[1];
      store_z[count] = v[2];
      for (int a = 0; a < 3; a++) begin
        if (v[a] < lo[a]) lo[a] = v[a];
        if (v[a] > hi[a]) hi[a] = v[a];
      end
      count++;
      return;
    end
    ext = 0;
    for (int a = 0; a < 3; a++) begin
      s[a] = lo[a] + hi[a];
      if (hi[a] - lo[a] > ext) ext = hi[a] - lo[a];
    end
    st = bbn_pkg::ST_OK;
    if (count == 0) st = bbn_pkg::ST_EMPTY;
    else if (overflowed) st = bbn_pkg::ST_OVERFLOW;
    else if (ext <= min_extent) st = bbn_pkg::ST_DEGENERATE;
    if (st != bbn_pkg::ST_OK) begin
      pending.push_back({48'd0, st, 1'b1});
    end else begin
      for (int i = 0; i < count; i++) begin
        logic [15:0] nx, ny, nz;
        nx = scaled(2 * store_x[i] - s[0], ext);
        ny = scaled(2 * store_y[i] - s[1], ext);
        nz = scaled(2 * store_z[i] - s[2], ext);
        pending.push_back({nx, ny, nz, bbn_pkg::ST_OK, i == count - 1});
      end
    end
    clear_mesh();
  endfunction

  // Compares one output item with the oldest expectation.
  function void check_result(logic [47:0] data, logic [1:0] st, logic last);
    logic [50:0] got;
    logic [50:0] exp;
    got = {data[15:0], data[31:16], data[47:32], st, last};
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected output item %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: x %0d/%0d y %0d/%0d z %0d/%0d st %0d/%0d last %0d/%0d",
                 $signed(exp[50:35]), $signed(data[15:0]),
                 $signed(exp[34:19]), $signed(data[31:16]),
                 $signed(exp[18:3]), $signed(data[47:32]),
                 exp[2:1], st, exp[0], last);
    end
  endfunction
endclass

module testbench;
  import bbn_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // x_coord, y_coord, z_coord
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // norm_x, norm_y, norm_z
  logic [1:0]  out_tuser;  // status
  logic        out_tlast;  // last_result
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  mesh_scoreboard board;
  int vertices_sent;
  int ends_sent;
  bit stall_enable;

  bounding_box_normalizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver stalls in a pattern of its own; checks happen at accepted edges.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        board.check_result(out_tdata, out_tuser, out_tlast);
      out_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Sends one item, with a random gap before some items. Valid stays
  // high after the accept so that the next item can follow back to back.
  task automatic send_item(bit is_end, logic [47:0] data);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_end;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(is_end, data);
    if (is_end) ends_sent++;
    else vertices_sent++;
  endtask

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    send_item(1'b0, {z, y, x});
  endtask

  // Ends the burst, waits until every expected item has arrived, then lets
  // the core settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_min_extent(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.min_extent = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random vertex, mostly clustered, sometimes at the extremes.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return 16'($urandom());
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  initial begin
    board = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    stall_enable = 0;
    vertices_sent = 0;
    ends_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty mesh, full-range box, degenerate box, overflow.
    send_item(1'b1, '0);
    send_vertex(16'sh7fff, 16'sh8000, 16'sd0);
    send_vertex(16'sh8000, 16'sh7fff, 16'sd1);
    send_vertex(16'sd0, 16'sd0, -16'sd1);
    send_item(1'b1, '0);
    send_vertex(16'sd5, 16'sd5, 16'sd5);
    send_item(1'b1, '0);
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sd3, 16'sd1, 16'sd2);
    send_vertex(16'sd1, 16'sd3, -16'sd3);
    send_item(1'b1, '0);
    drain();
    write_min_extent(16'd3);
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sd3, 16'sd0, 16'sd0);
    send_item(1'b1, '0);
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sd0, 16'sd4, 16'sd0);
    send_item(1'b1, '0);
    drain();
    write_min_extent(16'd0);
    for (int i = 0; i < 65; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
    send_item(1'b1, '0);
    for (int i = 0; i < 64; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
    send_item(1'b1, '0);
    drain();

    // Random meshes under several thresholds, with stalls on the output in all but the last phase.
    stall_enable = 1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_min_extent(16'd0);
        1: write_min_extent(16'($urandom_range(1, 2000)));
        2: write_min_extent(16'hffff);
        default: write_min_extent(16'($urandom_range(0, 300)));
      endcase
      for (int m = 0; m < 2; m++) begin
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
        send_item(1'b1, '0);
      end
      drain();
      stall_enable = (phase != 2);
    end
    drain();

    $display("Run covered %0d vertex items and %0d end items, %0d output items checked.",
             vertices_sent, ends_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
